[rtl/oqkr_pkg.sv]
`default_nettype none

package oqkr_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] CMD_APPEND    = 2'd0;
    localparam logic [1:0] CMD_REM_FRONT = 2'd1;
    localparam logic [1:0] CMD_REM_KEY   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic               exec;
        logic [1:0]         cmd;
        logic signed [31:0] key;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/oqkr_cell.sv]
`default_nettype none

module oqkr_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire oqkr_pkg::cell_ctrl_t ctrl,
    input  wire logic               prev_valid,
    input  wire logic               hit_in,
    input  wire logic               next_valid,
    input  wire logic signed [31:0] next_entry,
    output logic                    valid,
    output logic signed [31:0]      entry,
    output logic                    hit_out
);

    logic               valid_reg;
    logic               valid_next;
    logic signed [31:0] entry_reg;
    logic signed [31:0] entry_next;
    logic               match;
    logic               shift;
    logic               load;

    assign match   = valid_reg && (entry_reg == ctrl.key);
    assign hit_out = hit_in || match;

    // append lands in the first free cell
    assign load  = ctrl.exec && (ctrl.cmd == oqkr_pkg::CMD_APPEND) && !valid_reg && prev_valid;
    assign shift = ctrl.exec && valid_reg &&
                   ((ctrl.cmd == oqkr_pkg::CMD_REM_FRONT) ||
                    ((ctrl.cmd == oqkr_pkg::CMD_REM_KEY) && (hit_in || match)));

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (load)
        begin
            valid_next = 1'b1;
            entry_next = ctrl.key;
        end
        else if (shift)
        begin
            valid_next = next_valid;
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule

`default_nettype wire

[rtl/ordered_queue_with_key_removal_unit.sv]
// Ordered key list of up to oqkr_pkg::DEPTH signed 32-bit keys, oldest first.
// Command channel: a word (cmd, key) is taken at a rising edge with start high
// and busy low. cmd: append at back, remove front, remove first equal key.
// Result channel: status, removed_key and entry_count are shown for exactly one
// cycle with done high; the receiver cannot hold them off.
// Timing: a command taken at an edge executes in the cycle after it; the
// result is registered then and shown in the cycle after with done. busy
// is high in the execute cycle, so no command is taken until it is over.
// The row of cells does the execute step: every cell compares its entry
// with the key and may shift from its right neighbour in the single
// execute cycle, with a one-bit hit chain running along the row.
// Reset clears the count and all cell valid bits; the list is empty, busy and
// done are low. Stored keys are not cleared and are never read until written.
`default_nettype none

module ordered_queue_with_key_removal_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [1:0]         cmd,
    input  wire logic signed [31:0] key,
    output logic                    busy,
    output logic                    done,
    output logic [1:0]              status,
    output logic signed [31:0]      removed_key,
    output logic [4:0]              entry_count
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                         state_reg;
    oqkr_pkg::cell_ctrl_t           ctrl;
    logic [1:0]                     cmd_reg;
    logic signed [31:0]             key_reg;
    logic                           done_reg;
    logic [1:0]                     status_reg;
    logic [1:0]                     status_next;
    logic signed [31:0]             removed_reg;
    logic signed [31:0]             removed_next;
    logic [oqkr_pkg::CNT_W-1:0]     count_reg;
    logic [oqkr_pkg::CNT_W-1:0]     count_next;

    logic [oqkr_pkg::DEPTH-1:0]     valid_vec;
    logic [oqkr_pkg::DEPTH-1:0]     hit_vec;
    logic signed [31:0]             entry_vec [oqkr_pkg::DEPTH];
    logic                           empty;
    logic                           full;
    logic                           found;

    assign ctrl.exec = (state_reg == S_EXEC);
    assign ctrl.cmd  = cmd_reg;
    assign ctrl.key  = key_reg;

    genvar g;
    generate
        for (g = 0; g < oqkr_pkg::DEPTH; g++)
        begin : g_cell
            logic               pv;
            logic               hi;
            logic               nv;
            logic signed [31:0] ne;
            if (g == 0)
            begin : g_first
                assign pv = 1'b1;
                assign hi = 1'b0;
            end
            else
            begin : g_mid
                assign pv = valid_vec[g-1];
                assign hi = hit_vec[g-1];
            end
            if (g == oqkr_pkg::DEPTH - 1)
            begin : g_last
                assign nv = 1'b0;
                assign ne = '0;
            end
            else
            begin : g_inner
                assign nv = valid_vec[g+1];
                assign ne = entry_vec[g+1];
            end
            oqkr_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .prev_valid (pv),
                .hit_in     (hi),
                .next_valid (nv),
                .next_entry (ne),
                .valid      (valid_vec[g]),
                .entry      (entry_vec[g]),
                .hit_out    (hit_vec[g])
            );
        end
    endgenerate

    assign empty = !valid_vec[0];
    assign full  = valid_vec[oqkr_pkg::DEPTH-1];
    assign found = hit_vec[oqkr_pkg::DEPTH-1];

    always_comb
    begin
        status_next  = oqkr_pkg::ST_OK;
        removed_next = '0;
        count_next   = count_reg;
        case (cmd_reg)
            oqkr_pkg::CMD_APPEND:
            begin
                if (full)
                    status_next = oqkr_pkg::ST_FULL;
                else
                    count_next = count_reg + oqkr_pkg::CNT_W'(1);
            end
            oqkr_pkg::CMD_REM_FRONT:
            begin
                if (empty)
                    status_next = oqkr_pkg::ST_EMPTY;
                else
                begin
                    removed_next = entry_vec[0];
                    count_next   = count_reg - oqkr_pkg::CNT_W'(1);
                end
            end
            oqkr_pkg::CMD_REM_KEY:
            begin
                if (empty)
                    status_next = oqkr_pkg::ST_EMPTY;
                else if (!found)
                    status_next = oqkr_pkg::ST_NOT_FOUND;
                else
                begin
                    // a hit equals the key itself
                    removed_next = key_reg;
                    count_next   = count_reg - oqkr_pkg::CNT_W'(1);
                end
            end
            default:
            begin
                status_next = oqkr_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            done_reg    <= 1'b0;
            count_reg   <= '0;
            cmd_reg     <= oqkr_pkg::CMD_APPEND;
            key_reg     <= '0;
            status_reg  <= oqkr_pkg::ST_OK;
            removed_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg   <= cmd;
                        key_reg   <= key;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    status_reg  <= status_next;
                    removed_reg <= removed_next;
                    count_reg   <= count_next;
                    done_reg    <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (state_reg == S_EXEC);
    assign done        = done_reg;
    assign status      = status_reg;
    assign removed_key = removed_reg;
    assign entry_count = 5'(count_reg);

    // occupied cells form a solid run from the front
    a_valid_thermo: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec + oqkr_pkg::DEPTH'(1)) & valid_vec) == '0)
        else $error("valid cells not contiguous from front");

    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> ($countones(valid_vec) == int'(count_reg)))
        else $error("count disagrees with occupied cells");

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result word without execute cycle");

    a_start_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy ##1 done))
        else $error("accepted command did not execute");

    a_hit_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        busy && (cmd_reg == oqkr_pkg::CMD_REM_KEY) && found && !empty
        |=> (count_reg == $past(count_reg) - oqkr_pkg::CNT_W'(1)))
        else $error("matched key removal did not shrink list");

endmodule

`default_nettype wire

[dv/oqkr_list_checker.sv]
`timescale 1ns / 100ps

module oqkr_list_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         cmd,
    input  logic signed [31:0] key,
    input  logic               done,
    input  logic [1:0]         status,
    input  logic signed [31:0] removed_key,
    input  logic [4:0]         entry_count,
    output int                 fails,
    output int                 awaited,
    output int                 checked,
    output logic [3:0]         statuses_seen
);

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] removed_key;
        logic [4:0]         entry_count;
    } outcome_t;

    logic signed [31:0] list_keys[$];
    outcome_t           pending_outcomes[$];
    outcome_t           want;

    initial
    begin
        fails = 0;
        awaited = 0;
        checked = 0;
        statuses_seen = '0;
    end

    function automatic outcome_t apply_command(input logic [1:0] c,
                                               input logic signed [31:0] k);
        outcome_t r;
        int       idx;
        logic     hit;
        r.status = oqkr_pkg::ST_OK;
        r.removed_key = '0;
        hit = 1'b0;
        case (c)
            oqkr_pkg::CMD_APPEND:
            begin
                if (list_keys.size() >= oqkr_pkg::DEPTH)
                    r.status = oqkr_pkg::ST_FULL;
                else
                    list_keys.push_back(k);
            end
            oqkr_pkg::CMD_REM_FRONT:
            begin
                if (list_keys.size() == 0)
                    r.status = oqkr_pkg::ST_EMPTY;
                else
                    r.removed_key = list_keys.pop_front();
            end
            oqkr_pkg::CMD_REM_KEY:
            begin
                if (list_keys.size() == 0)
                    r.status = oqkr_pkg::ST_EMPTY;
                else
                begin
                    r.status = oqkr_pkg::ST_NOT_FOUND;
                    for (idx = 0; idx < list_keys.size() && !hit; idx++)
                    begin
                        if (list_keys[idx] == k)
                        begin
                            hit = 1'b1;
                            r.removed_key = k;
                            r.status = oqkr_pkg::ST_OK;
                            list_keys.delete(idx);
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.entry_count = 5'(list_keys.size());
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_keys.delete();
            pending_outcomes.delete();
            awaited <= 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    $display("%0t: result word with none awaited (status %0d, key %0d, count %0d)",
                             $time, status, removed_key, entry_count);
                    fails = fails + 1;
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    checked = checked + 1;
                    statuses_seen[status] = 1'b1;
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, status);
                        fails = fails + 1;
                    end
                    if (removed_key !== want.removed_key)
                    begin
                        $display("%0t: removed_key expected %0d, got %0d",
                                 $time, want.removed_key, removed_key);
                        fails = fails + 1;
                    end
                    if (entry_count !== want.entry_count)
                    begin
                        $display("%0t: entry_count expected %0d, got %0d",
                                 $time, want.entry_count, entry_count);
                        fails = fails + 1;
                    end
                end
            end
            if (start && !busy)
                pending_outcomes.push_back(apply_command(cmd, key));
            awaited <= pending_outcomes.size();
        end
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         PHASE_WORDS  = 642;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         DRAIN_CYCLES = 8;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [1:0]         cmd = oqkr_pkg::CMD_APPEND;
    logic signed [31:0] key = '0;
    logic               busy;
    logic               done;
    logic [1:0]         status;
    logic signed [31:0] removed_key;
    logic [4:0]         entry_count;

    int                 fails;
    int                 awaited;
    int                 checked;
    logic [3:0]         statuses_seen;
    int                 words_sent = 0;
    int                 cycles = 0;

    always #2 clk = ~clk;

    ordered_queue_with_key_removal_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd),
        .key         (key),
        .busy        (busy),
        .done        (done),
        .status      (status),
        .removed_key (removed_key),
        .entry_count (entry_count)
    );

    oqkr_list_checker u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .key           (key),
        .done          (done),
        .status        (status),
        .removed_key   (removed_key),
        .entry_count   (entry_count),
        .fails         (fails),
        .awaited       (awaited),
        .checked       (checked),
        .statuses_seen (statuses_seen)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, awaited);
            $display("ordered_queue_with_key_removal_unit: mismatch");
            $finish;
        end
    end

    task automatic send_word(input logic [1:0] c, input logic signed [31:0] k);
        start <= 1'b1;
        cmd <= c;
        key <= k;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic hold_off(input int pct);
        while ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (awaited != 0);
    endtask

    // small pool so that searches hit and duplicates occur
    function automatic logic signed [31:0] pool_key();
        case ($urandom_range(7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            4:       return 32'sh5555_5555;
            5:       return 32'shaaaa_aaaa;
            default: return $urandom_range(5);
        endcase
    endfunction

    task automatic random_phase(input int pct, input int words);
        int                 n;
        int                 fill_bias;
        logic [1:0]         c;
        logic signed [31:0] k;
        fill_bias = 50;
        for (n = 0; n < words; n++)
        begin
            // alternate filling and draining stretches so both ends are reached
            if (n % 40 == 0)
                fill_bias = $urandom_range(20, 80);
            if ($urandom_range(99) < 3)
                c = CMD_UNUSED;
            else if ($urandom_range(99) < fill_bias)
                c = oqkr_pkg::CMD_APPEND;
            else if ($urandom_range(1) == 1)
                c = oqkr_pkg::CMD_REM_KEY;
            else
                c = oqkr_pkg::CMD_REM_FRONT;
            if ($urandom_range(99) < 80)
                k = pool_key();
            else
                k = $urandom;
            send_word(c, k);
            hold_off(pct);
        end
    endtask

    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(oqkr_pkg::CMD_REM_FRONT, 32'sd0);
        send_word(oqkr_pkg::CMD_REM_KEY, 32'sd5);
        send_word(CMD_UNUSED, -32'sd1);
        send_word(oqkr_pkg::CMD_APPEND, 32'sh8000_0000);
        send_word(oqkr_pkg::CMD_APPEND, 32'sh7fff_ffff);
        send_word(oqkr_pkg::CMD_APPEND, 32'sd0);
        send_word(oqkr_pkg::CMD_APPEND, -32'sd1);
        send_word(oqkr_pkg::CMD_APPEND, 32'sd7);
        send_word(oqkr_pkg::CMD_APPEND, 32'sd3);
        send_word(oqkr_pkg::CMD_APPEND, 32'sd7);
        send_word(oqkr_pkg::CMD_APPEND, 32'sh5555_5555);
        send_word(oqkr_pkg::CMD_APPEND, 32'shaaaa_aaaa);
        send_word(oqkr_pkg::CMD_APPEND, 32'sd1);
        send_word(oqkr_pkg::CMD_APPEND, 32'sd2);
        send_word(oqkr_pkg::CMD_APPEND, 32'sd3);
        send_word(oqkr_pkg::CMD_APPEND, 32'sd4);
        send_word(oqkr_pkg::CMD_APPEND, 32'sd5);
        send_word(oqkr_pkg::CMD_APPEND, 32'sd6);
        send_word(oqkr_pkg::CMD_APPEND, 32'sd9);
        send_word(oqkr_pkg::CMD_APPEND, 32'sd11);
        send_word(CMD_UNUSED, 32'sd7);
        send_word(oqkr_pkg::CMD_REM_KEY, 32'sd7);
        send_word(oqkr_pkg::CMD_REM_KEY, 32'sd12345);
        send_word(oqkr_pkg::CMD_REM_KEY, 32'sd9);
        send_word(oqkr_pkg::CMD_REM_FRONT, 32'sd0);
        wait_drained();

        random_phase(14, PHASE_WORDS);
        wait_drained();
        random_phase(60, PHASE_WORDS);
        random_phase(0, PHASE_WORDS);

        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("%0d command words over %0d cycles, %0d results checked, %0d faults",
                 words_sent, cycles, checked, fails);
        $display("status codes seen (full/not found/empty/ok): %b, list filled and emptied",
                 statuses_seen);
        if (fails == 0)
            $display("ordered_queue_with_key_removal_unit: match");
        else
            $display("ordered_queue_with_key_removal_unit: mismatch");
        $finish;
    end

endmodule
